// File: src/g2e_pkg.sv
// Shared types, constants and helpers for the geodetic to ECEF converter.
package g2e_pkg;

    localparam int unsigned ROTATION_STEPS_DEF = 32;
    localparam int unsigned NEWTON_STEPS = 4;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
    localparam logic [63:0] THREE_Q62 = 64'hC000000000000000;
    localparam logic [63:0] DEG7_TO_RAD_Q63 = (PI_Q62 + 64'd450000000) / 64'd900000000;
    localparam logic [63:0] CORDIC_START_Q62 = 64'd667681663043 << 22;
    localparam logic [63:0] E2_Q62 = 64'd30872378602574708;
    localparam logic [63:0] ONE_MINUS_E2_Q62 = ONE_Q62 - E2_Q62;
    localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
    localparam logic signed [33:0] QUARTER_DEG7 = 34'sd900000000;
    localparam logic signed [33:0] REDUCE_OFFSET = 34'sd4050000000;

    // Magnitude with a sign flag.
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
    } smag_t;

    // Sine and cosine of one angle.
    typedef struct packed {
        smag_t co;
        smag_t si;
    } trig_t;

    // atan(2^-i) in Q62; constant folded at elaboration.
    function automatic logic [63:0] atan_q62(input int unsigned i);
        logic [63:0] acc;
        logic [63:0] term;
        acc = '0;
        if (i == 0)
        begin
            return PI_Q62 >> 2;
        end
        for (int unsigned k = 0; k < 32; k++)
        begin
            if (i * (2 * k + 1) <= 62)
            begin
                term = (ONE_Q62 >> (i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k[0])
                    acc = acc - term;
                else
                    acc = acc + term;
            end
        end
        return acc;
    endfunction

    // Arithmetic shift right, floor rounding.
    function automatic logic [63:0] asr(input logic [63:0] u, input int unsigned s);
        return 64'($signed(u) >>> s);
    endfunction

endpackage

// File: src/g2e_sincos.sv
// Pipelined CORDIC sine and cosine, and the registered rounded multiplier.
module g2e_sincos
    import g2e_pkg::*;
#(
    parameter int unsigned ROTATION_STEPS = ROTATION_STEPS_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  angle,
    output trig_t               trig
);
    // Stage 0: quadrant reduction.
    logic [1:0]         q_reg;
    logic               rneg_reg;
    logic [29:0]        rmag_reg;
    logic signed [33:0] w;
    logic [33:0]        qw;
    logic [1:0]         q_next;
    logic signed [33:0] r_next;

    always_comb
    begin
        w = 34'(angle) + REDUCE_OFFSET;
        if (w >= 34'sd2700000000)
            qw = 34'd3;
        else if (w >= 34'sd1800000000)
            qw = 34'd2;
        else if (w >= 34'sd900000000)
            qw = 34'd1;
        else
            qw = 34'd0;
        // w reaches about 6.2e9, so also check higher quadrants
        if (w >= 34'sd7200000000)
            qw = 34'd8;
        else if (w >= 34'sd6300000000)
            qw = 34'd7;
        else if (w >= 34'sd5400000000)
            qw = 34'd6;
        else if (w >= 34'sd4500000000)
            qw = 34'd5;
        else if (w >= 34'sd3600000000)
            qw = 34'd4;
        q_next = qw[1:0];
        r_next = w - $signed(qw) * QUARTER_DEG7 - (QUARTER_DEG7 >>> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg    <= q_next;
            rneg_reg <= r_next[33];
            rmag_reg <= r_next[33] ? 30'(-r_next) : 30'(r_next);
        end
    end

    // Stage 1: degrees to radians.
    logic [63:0] z0_reg;
    logic [1:0]  q1_reg;
    logic        rneg1_reg;
    logic [93:0] zp;

    assign zp = {64'd0, rmag_reg} * {30'd0, DEG7_TO_RAD_Q63};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg    <= 64'((zp + 94'd1) >> 1);
            q1_reg    <= q_reg;
            rneg1_reg <= rneg_reg;
        end
    end

    // CORDIC rotation stages, one iteration each.
    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_rot
        localparam logic [63:0] ATAN_I = atan_q62(i);
        logic [63:0] xi, yi, zi;
        logic [1:0]  qi;
        logic        ni;
        logic [63:0] x_reg, y_reg, z_reg;
        logic [1:0]  qs_reg;
        logic        ns_reg;

        if (i == 0)
        begin : g_src
            assign xi = CORDIC_START_Q62;
            assign yi = '0;
            assign zi = z0_reg;
            assign qi = q1_reg;
            assign ni = rneg1_reg;
        end
        else
        begin : g_src
            assign xi = g_rot[i-1].x_reg;
            assign yi = g_rot[i-1].y_reg;
            assign zi = g_rot[i-1].z_reg;
            assign qi = g_rot[i-1].qs_reg;
            assign ni = g_rot[i-1].ns_reg;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zi[63])
                begin
                    x_reg <= xi + asr(yi, i);
                    y_reg <= yi - asr(xi, i);
                    z_reg <= zi + ATAN_I;
                end
                else
                begin
                    x_reg <= xi - asr(yi, i);
                    y_reg <= yi + asr(xi, i);
                    z_reg <= zi - ATAN_I;
                end
                qs_reg <= qi;
                ns_reg <= ni;
            end
        end
    end

    // Quadrant mapping.
    smag_t c, s;
    logic [63:0] xf, yf;
    trig_t trig_next;

    always_comb
    begin
        xf = g_rot[ROTATION_STEPS-1].x_reg;
        yf = g_rot[ROTATION_STEPS-1].y_reg;
        c.neg = xf[63];
        c.mag = xf[63] ? -xf : xf;
        s.neg = yf[63] ^ g_rot[ROTATION_STEPS-1].ns_reg;
        s.mag = yf[63] ? -yf : yf;
        unique case (g_rot[ROTATION_STEPS-1].qs_reg)
            2'd0:    trig_next = '{co: c, si: s};
            2'd1:    trig_next = '{co: '{mag: s.mag, neg: !s.neg}, si: c};
            2'd2:    trig_next = '{co: '{mag: c.mag, neg: !c.neg},
                                   si: '{mag: s.mag, neg: !s.neg}};
            default: trig_next = '{co: s, si: '{mag: c.mag, neg: !c.neg}};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            trig <= trig_next;
    end
endmodule

// Rounded product (a*b + 2^(SHIFT-1)) >> SHIFT, kept to 64 bits, registered.
module g2e_mul #(
    parameter int unsigned SHIFT = 62
) (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] prod
);
    // First, four 32x32 partial products, registered.
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] sum;
    logic [63:0]  prod_reg;

    always_ff @(posedge clk)
    begin
        p00_reg <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
        p01_reg <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
        p10_reg <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
        p11_reg <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
    end

    // Then sum, round, select, registered into prod_reg.
    assign sum = {p11_reg, 64'd0} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0}
               + {64'd0, p00_reg} + (128'd1 << (SHIFT - 1));

    always_ff @(posedge clk)
    begin
        prod_reg <= sum[SHIFT +: 64];
    end

    assign prod = prod_reg;
endmodule

// File: src/geodetic_to_ecef.sv
// Top level: WGS84 geodetic to ECEF converter, fully pipelined.
// The pipeline runs through ROTATION_STEPS + 3 trig stages, 17 chained rounded
// multiplies (4 Newton steps of three), the final products and one rounding stage.
// Throughput: one transaction per cycle; busy is always low; receiver cannot stall.
// Reset (rst_n, async low) clears the valid pipe only; data regs need none.
module geodetic_to_ecef
    import g2e_pkg::*;
#(
    parameter int unsigned ROTATION_STEPS = ROTATION_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [30:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic signed [27:0] height,
    output logic               done,
    output logic signed [33:0] ecef_x,
    output logic signed [33:0] ecef_y,
    output logic signed [33:0] ecef_z
);
    localparam int unsigned TRIG_LAT = ROTATION_STEPS + 3;
    // Multiply steps: sp^2, d, three per Newton step, nq, nb, p.
    localparam int unsigned NR_END = 2 + 3 * NEWTON_STEPS;
    localparam int unsigned NSTEP = NR_END + 3;
    localparam int unsigned POST = 2 * NSTEP + 3;
    localparam int unsigned LAT = TRIG_LAT + POST;

    logic en;
    assign en = 1'b1;
    assign busy = 1'b0;

    // Valid pipe.
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end
    assign done = vld_reg[LAT-1];

    trig_t tlat, tlon;
    g2e_sincos #(.ROTATION_STEPS(ROTATION_STEPS)) u_lat (
        .clk(clk), .en(en), .angle(32'(latitude)), .trig(tlat));
    g2e_sincos #(.ROTATION_STEPS(ROTATION_STEPS)) u_lon (
        .clk(clk), .en(en), .angle(longitude), .trig(tlon));

    // Height delayed to meet the trig results.
    logic [TRIG_LAT-1:0][27:0] h_pipe_reg;
    always_ff @(posedge clk)
    begin
        h_pipe_reg <= {h_pipe_reg[TRIG_LAT-2:0], height};
    end

    // Post pipeline word: trig carried along, a/b/t are working values.
    typedef struct packed {
        trig_t       lat;
        trig_t       lon;
        logic        hneg;
        logic [63:0] hq;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] t;
    } post_t;

    post_t head;
    logic signed [27:0] hh;

    always_comb
    begin
        hh = h_pipe_reg[TRIG_LAT-1];
        head.lat  = tlat;
        head.lon  = tlon;
        head.hneg = hh[27];
        head.hq   = (hh[27] ? 64'd0 - 64'(hh) : 64'(hh)) << 20;
        head.a    = '0;
        head.b    = '0;
        head.t    = '0;
    end

    // One rounded multiply per step:
    // 0: a = sp^2; 1: a = d, b = 1; Newton u = y^2, u = d*u, y = y(3-u)/2;
    // then b = nq; a = rad, b = rz; a = p.
    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        localparam int unsigned PH = (j >= 2 && j < NR_END) ? (j - 2) % 3 : 3;
        localparam int unsigned SH = (j == NR_END) ? 42 : ((PH == 2) ? 63 : 62);
        post_t cur, nxt, s1_reg, s2_reg;
        logic [63:0] op_x, op_y, prod;

        if (j == 0)
        begin : g_src
            assign cur = head;
        end
        else
        begin : g_src
            assign cur = g_step[j-1].nxt;
        end

        always_comb
        begin
            op_x = cur.b;
            op_y = cur.b;
            if (j == 0)
            begin
                op_x = cur.lat.si.mag;
                op_y = cur.lat.si.mag;
            end
            else if (j == 1)
            begin
                op_x = E2_Q62;
                op_y = cur.a;
            end
            else if (PH == 1)
            begin
                op_x = cur.a;
                op_y = cur.t;
            end
            else if (PH == 2)
            begin
                op_x = cur.b;
                op_y = THREE_Q62 - cur.t;
            end
            else if (j == NR_END)
            begin
                op_x = SEMI_MAJOR_MM;
                op_y = cur.b;
            end
            else if (j == NR_END + 1)
            begin
                op_x = cur.b;
                op_y = ONE_MINUS_E2_Q62;
            end
            else if (j == NR_END + 2)
            begin
                op_x = cur.a;
                op_y = cur.lat.co.mag;
            end
        end

        g2e_mul #(.SHIFT(SH)) u_mul (.clk(clk), .a(op_x), .b(op_y), .prod(prod));

        always_ff @(posedge clk)
        begin
            s1_reg <= cur;
            s2_reg <= s1_reg;
        end

        always_comb
        begin
            nxt = s2_reg;
            if (j == 0)
                nxt.a = prod;
            else if (j == 1)
            begin
                nxt.a = ONE_Q62 - prod;
                nxt.b = ONE_Q62;
            end
            else if (PH == 0 || PH == 1)
                nxt.t = prod;
            else if (PH == 2 || j == NR_END)
                nxt.b = prod;
            else if (j == NR_END + 1)
            begin
                // rad from nq, rz from nb
                nxt.a = s2_reg.hneg ? s2_reg.b - s2_reg.hq : s2_reg.b + s2_reg.hq;
                nxt.b = s2_reg.hneg ? prod - s2_reg.hq : prod + s2_reg.hq;
            end
            else
                nxt.a = prod;
        end
    end

    // Final products, signs travel alongside in sgn1_reg and sgn2_reg.
    post_t fin;
    logic [63:0] px, py, pz;
    logic [2:0] sgn1_reg, sgn2_reg;

    assign fin = g_step[NSTEP-1].nxt;

    g2e_mul #(.SHIFT(62)) u_px (.clk(clk), .a(fin.a), .b(fin.lon.co.mag), .prod(px));
    g2e_mul #(.SHIFT(62)) u_py (.clk(clk), .a(fin.a), .b(fin.lon.si.mag), .prod(py));
    g2e_mul #(.SHIFT(62)) u_pz (.clk(clk), .a(fin.b), .b(fin.lat.si.mag), .prod(pz));

    always_ff @(posedge clk)
    begin
        sgn1_reg <= {fin.lat.co.neg ^ fin.lon.co.neg,
                     fin.lat.co.neg ^ fin.lon.si.neg,
                     fin.lat.si.neg};
        sgn2_reg <= sgn1_reg;
    end

    function automatic logic [33:0] pack(input logic [63:0] q20, input logic neg);
        logic [63:0] m;
        m = (q20 + 64'd524288) >> 20;
        return neg ? 34'(-m) : 34'(m);
    endfunction

    always_ff @(posedge clk)
    begin
        ecef_x <= pack(px, sgn2_reg[2]);
        ecef_y <= pack(py, sgn2_reg[1]);
        ecef_z <= pack(pz, sgn2_reg[0]);
    end
endmodule
